// ----- rtl/core/hnm_pkg.sv -----
// Package for the heightmap normal generator: state codes, register indexes
// and fixed-point constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hnm_pkg;

  localparam int unsigned QOne = 16384;

  localparam int unsigned CfgDataWidth = 13;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_CALC,
    ST_START,
    ST_NORM,
    ST_LOAD
  } ctrl_state_e;

  typedef enum logic [1:0] {
    NU_IDLE,
    NU_SQ,
    NU_MUL,
    NU_CMP
  } norm_state_e;

endpackage
`default_nettype wire

// ----- rtl/core/hnm_if.sv -----
// Stream interfaces for the heightmap normal generator: pixel input and
// normal output, each with valid/ready. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface hnm_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] sample;
  modport source (output valid, command, sample, input ready);
  modport sink (input valid, command, sample, output ready);
endinterface

interface hnm_out_if;
  logic              valid;
  logic              ready;
  logic [9:0]        column;
  logic [11:0]       row;
  logic signed [8:0] height_quarters;
  logic signed [15:0] normal_x;
  logic [14:0]       normal_y;
  logic signed [15:0] normal_z;
  logic              frame_end;
  modport source (output valid, column, row, height_quarters, normal_x, normal_y,
                  normal_z, frame_end, input ready);
  modport sink (input valid, column, row, height_quarters, normal_x, normal_y,
                normal_z, frame_end, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/hnm_ram.sv -----
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module hnm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 3072
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/core/hnm_norm.sv -----
// Bit-serial normalizer: round(16384 * c / sqrt(s)), one result bit at a time
// through square, multiply and compare steps. Depends on hnm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hnm_norm (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [7:0]  c_i,
  input  wire logic [16:0] s_i,
  output logic [14:0]      mag_o,
  output logic             done_o
);
  import hnm_pkg::*;

  norm_state_e state_q, state_d;
  logic [7:0]  c_q;
  logic [16:0] s_q;
  logic [14:0] q_q;
  logic [3:0]  bit_q;
  logic [29:0] osq_q;
  logic [46:0] prod_q;
  logic        done_q;
  logic [14:0] cand;
  logic [14:0] odd;
  logic [46:0] rhs;

  assign cand = q_q | (15'd1 << bit_q);
  assign odd  = {cand[13:0], 1'b0} - 15'd1;
  assign rhs  = {1'b0, 16'(c_q * c_q), 30'd0};

  always_comb begin
    state_d = state_q;
    case (state_q)
      NU_IDLE: if (start_i) state_d = NU_SQ;
      NU_SQ:   state_d = NU_MUL;
      NU_MUL:  state_d = NU_CMP;
      NU_CMP:  state_d = (bit_q == 4'd0) ? NU_IDLE : NU_SQ;
      default: state_d = NU_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NU_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == NU_CMP) && (bit_q == 4'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      NU_IDLE: begin
        if (start_i) begin
          c_q   <= c_i;
          s_q   <= s_i;
          q_q   <= '0;
          bit_q <= 4'd14;
        end
      end
      NU_SQ:  osq_q <= 30'(odd * odd);
      NU_MUL: prod_q <= 47'(osq_q * s_q);
      NU_CMP: begin
        if ((32'(cand) <= QOne) && (prod_q <= rhs)) begin
          q_q <= cand;
        end
        bit_q <= bit_q - 4'd1;
      end
      default: ;
    endcase
  end

  assign mag_o  = q_q;
  assign done_o = done_q;
endmodule
`default_nettype wire

// ----- rtl/core/heightmap_normal_generator.sv -----
// Heightmap normal generator: accepts one transaction at a time in the idle state.
// A pixel that only writes passes through accept and write; a pixel with a result
// passes through accept, write, four line-store reads, calc, start, normalizing of
// 15 result bits, done and load; a flush takes this path without the write, and
// output stalls hold the load. Ignored items are dropped. rst_ni clears counters
// and control; line store not cleared. Depends on hnm_pkg, hnm_if, hnm_ram, hnm_norm.
`timescale 1ns / 1ps
`default_nettype none
module heightmap_normal_generator #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_index_i,
  input  wire logic [hnm_pkg::CfgDataWidth-1:0] cfg_data_i,
  hnm_in_if.sink                            in_i,
  hnm_out_if.source                         out_o
);
  import hnm_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned Depth = 3 * MAX_WIDTH;
  localparam int unsigned AW = $clog2(Depth);

  ctrl_state_e state_q, state_d;

  logic [10:0] frame_width_q;
  logic [12:0] frame_height_q;
  logic [31:0] eff_w, eff_h;

  logic [CW-1:0] in_col_q, out_col_q;
  logic [RW-1:0] in_row_q, out_row_q;
  logic [1:0]    in_slot_q, out_slot_q;
  logic          draining_q;

  logic [CW-1:0] it_col_q;
  logic [RW-1:0] it_row_q;
  logic [1:0]    it_slot_q, it_dslot_q;
  logic [7:0]    it_up_q, it_sample_q;
  logic          it_self_up_q, it_last_q, it_emit_q;

  logic [7:0] self_q, left_q, right_q;
  logic signed [8:0] a_q, b_q;
  logic [16:0] s_q;

  logic       accept;
  logic       ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0] ram_rdata;
  logic       norm_start;
  logic [14:0] mag_x, mag_y, mag_z;
  logic        done_x, done_y, done_z;
  logic        out_valid_q;
  logic        out_free;

  logic signed [8:0] a_d, b_d;
  logic [7:0] up_v;

  function automatic logic [AW-1:0] slot_base(input logic [1:0] slot);
    logic [AW-1:0] base;
    case (slot)
      2'd1:    base = AW'(MAX_WIDTH);
      2'd2:    base = AW'(2 * MAX_WIDTH);
      default: base = '0;
    endcase
    return base;
  endfunction

  function automatic logic [1:0] slot_prev(input logic [1:0] slot);
    return (slot == 2'd0) ? 2'd2 : slot - 2'd1;
  endfunction

  always_comb begin
    eff_w = 32'(frame_width_q);
    if (eff_w < 32'd1) eff_w = 32'd1;
    if (eff_w > MAX_WIDTH) eff_w = MAX_WIDTH;
    eff_h = 32'(frame_height_q);
    if (eff_h < 32'd1) eff_h = 32'd1;
    if (eff_h > MAX_HEIGHT) eff_h = MAX_HEIGHT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= 11'd1024;
      frame_height_q <= 13'd1024;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[10:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          if (draining_q && in_i.command) state_d = ST_RD0;
          else if (!draining_q && !in_i.command) state_d = ST_WR;
        end
      end
      ST_WR:    state_d = it_emit_q ? ST_RD0 : ST_IDLE;
      ST_RD0:   state_d = ST_RD1;
      ST_RD1:   state_d = ST_RD2;
      ST_RD2:   state_d = ST_RD3;
      ST_RD3:   state_d = ST_CALC;
      ST_CALC:  state_d = ST_START;
      ST_START: state_d = ST_NORM;
      ST_NORM:  if (done_x) state_d = ST_LOAD;
      ST_LOAD:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = slot_base(it_slot_q) + AW'(it_col_q);
    norm_start = 1'b0;
    case (state_q)
      ST_IDLE: in_i.ready = 1'b1;
      ST_WR: begin
        ram_we   = 1'b1;
        ram_addr = slot_base(in_slot_q == it_slot_q ? in_slot_q : it_slot_q)
                   + AW'(it_col_q);
      end
      ST_RD1: begin
        ram_addr = slot_base(it_slot_q)
                   + AW'((it_col_q != '0) ? it_col_q - CW'(1) : it_col_q);
      end
      ST_RD2: begin
        ram_addr = slot_base(it_slot_q)
                   + AW'((32'(it_col_q) + 32'd1 < eff_w) ? it_col_q + CW'(1) : it_col_q);
      end
      ST_RD3: begin
        ram_addr = slot_base((it_row_q != '0) ? it_dslot_q : it_slot_q) + AW'(it_col_q);
      end
      ST_START: norm_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
      draining_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_LOAD && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      if (accept) begin
        if (draining_q && in_i.command) begin
          if (32'(out_col_q) + 32'd1 >= eff_w) begin
            draining_q <= 1'b0;
            in_col_q   <= '0;
            in_row_q   <= '0;
            in_slot_q  <= '0;
            out_col_q  <= '0;
            out_row_q  <= '0;
            out_slot_q <= '0;
          end else begin
            out_col_q <= out_col_q + CW'(1);
          end
        end else if (!draining_q && !in_i.command) begin
          if (32'(in_col_q) + 32'd1 >= eff_w) begin
            in_col_q <= '0;
            if (32'(in_row_q) + 32'd1 >= eff_h) begin
              draining_q <= 1'b1;
              out_col_q  <= '0;
              out_row_q  <= in_row_q;
              out_slot_q <= in_slot_q;
            end else begin
              in_row_q  <= in_row_q + RW'(1);
              in_slot_q <= (in_slot_q == 2'd2) ? 2'd0 : in_slot_q + 2'd1;
            end
          end else begin
            in_col_q <= in_col_q + CW'(1);
          end
        end
      end
    end
  end

  assign up_v = it_self_up_q ? self_q : it_up_q;
  assign a_d  = $signed({1'b0, left_q}) - $signed({1'b0, right_q});
  assign b_d  = $signed({1'b0, ram_rdata}) - $signed({1'b0, up_v});

  always_ff @(posedge clk_i) begin
    if (accept) begin
      it_sample_q <= in_i.sample;
      if (draining_q) begin
        it_col_q     <= out_col_q;
        it_row_q     <= out_row_q;
        it_slot_q    <= out_slot_q;
        it_dslot_q   <= slot_prev(out_slot_q);
        it_up_q      <= in_i.sample;
        it_self_up_q <= 1'b1;
        it_last_q    <= (32'(out_col_q) + 32'd1 >= eff_w);
        it_emit_q    <= 1'b1;
      end else begin
        it_col_q     <= in_col_q;
        it_row_q     <= in_row_q - RW'(1);
        it_slot_q    <= in_slot_q;
        it_dslot_q   <= slot_prev(slot_prev(in_slot_q));
        it_up_q      <= in_i.sample;
        it_self_up_q <= 1'b0;
        it_last_q    <= 1'b0;
        it_emit_q    <= (in_row_q != '0);
      end
    end
    if (state_q == ST_WR) begin
      it_slot_q <= slot_prev(it_slot_q);
    end
    case (state_q)
      ST_RD1: self_q  <= ram_rdata;
      ST_RD2: left_q  <= ram_rdata;
      ST_RD3: right_q <= ram_rdata;
      ST_CALC: begin
        a_q <= a_d;
        b_q <= b_d;
        s_q <= 17'(a_d * a_d) + 17'(b_d * b_d) + 17'd64;
      end
      default: ;
    endcase
    if (state_q == ST_LOAD && out_free) begin
      out_o.column          <= 10'(it_col_q);
      out_o.row             <= 12'(it_row_q);
      out_o.height_quarters <= $signed({1'b0, self_q}) - 9'sd64;
      out_o.normal_x        <= a_q[8] ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
      out_o.normal_y        <= mag_y;
      out_o.normal_z        <= b_q[8] ? -$signed({1'b0, mag_z}) : $signed({1'b0, mag_z});
      out_o.frame_end       <= it_last_q;
    end
  end

  assign out_o.valid = out_valid_q;

  hnm_ram #(
    .Width(8),
    .Depth(Depth)
  ) u_row_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(it_sample_q),
    .rdata_o(ram_rdata)
  );

  hnm_norm u_norm_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(norm_start),
    .c_i    (a_q[8] ? 8'(-a_q) : a_q[7:0]),
    .s_i    (s_q),
    .mag_o  (mag_x),
    .done_o (done_x)
  );

  hnm_norm u_norm_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(norm_start),
    .c_i    (8'd8),
    .s_i    (s_q),
    .mag_o  (mag_y),
    .done_o (done_y)
  );

  hnm_norm u_norm_z (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(norm_start),
    .c_i    (b_q[8] ? 8'(-b_q) : b_q[7:0]),
    .s_i    (s_q),
    .mag_o  (mag_z),
    .done_o (done_z)
  );

`ifndef NO_ASSERTIONS
  a_norm_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_x == done_y) && (done_y == done_z))
    else $error("normalizers out of step");
  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_LOAD)
    else $error("result raised outside load");
  a_drain_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(draining_q) |-> (in_col_q == '0) && (in_row_q == '0) && (in_slot_q == '0))
    else $error("counters not cleared after drain");
`endif
endmodule
`default_nettype wire

// ----- tb/heightmap_normal_generator_checker.sv -----
// Checker for the heightmap normal generator: watches the config port and both
// stream channels, predicts every normal and compares. Depends on hnm_pkg, hnm_if.
`timescale 1ns / 1ps
module heightmap_normal_generator_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [hnm_pkg::CfgDataWidth-1:0]  cfg_data_i,
  hnm_in_if                                 pix_mon,
  hnm_out_if                                nrm_mon,
  output int                                errors_o,
  output int                                pending_o
);
  import hnm_pkg::*;

  localparam int unsigned MaxW = 1024;
  localparam int unsigned MaxH = 4096;

  typedef struct packed {
    logic [9:0]         column;
    logic [11:0]        row;
    logic signed [8:0]  height_quarters;
    logic signed [15:0] normal_x;
    logic [14:0]        normal_y;
    logic signed [15:0] normal_z;
    logic               frame_end;
  } normal_t;

  normal_t     normal_q[$];
  logic [7:0]  line_mem [3*MaxW];
  int unsigned wr_col, wr_row, dr_col, dr_row, cfg_w, cfg_h;
  bit          draining;

  function automatic int unsigned width_eff();
    return cfg_w < 1 ? 1 : (cfg_w > MaxW ? MaxW : cfg_w);
  endfunction

  function automatic int unsigned height_eff();
    return cfg_h < 1 ? 1 : (cfg_h > MaxH ? MaxH : cfg_h);
  endfunction

  function automatic int unsigned pix(int unsigned r, int unsigned c);
    return line_mem[(r % 3) * MaxW + c];
  endfunction

  // round(16384 * c / sqrt(s)), ties away from zero
  function automatic int unsigned unit_mag(int unsigned c, longint unsigned s);
    longint unsigned cc, rhs, odd;
    int unsigned q, cand;
    cc = c;
    rhs = cc * cc * 64'd4 * 64'd16384 * 64'd16384;
    q = 0;
    for (int b = 14; b >= 0; b--) begin
      cand = q | (1 << b);
      if (cand <= QOne) begin
        odd = 2 * longint'(cand) - 1;
        if (odd * odd * s <= rhs) q = cand;
      end
    end
    return q;
  endfunction

  function automatic logic [15:0] signed_unit(int d, longint unsigned s);
    int unsigned m;
    m = unit_mag(d < 0 ? -d : d, s);
    return d < 0 ? 16'(-int'(m)) : 16'(m);
  endfunction

  function automatic normal_t surface_normal(int unsigned c, int unsigned r, int unsigned up,
                                             bit last);
    normal_t n;
    int unsigned self, lf, rt, dn;
    int a, b;
    longint unsigned s;
    self = pix(r, c);
    lf = c > 0 ? pix(r, c - 1) : self;
    rt = (c + 1 < width_eff()) ? pix(r, c + 1) : self;
    dn = r > 0 ? pix(r - 1, c) : self;
    a = int'(lf) - int'(rt);
    b = int'(dn) - int'(up);
    s = longint'(a * a + 64 + b * b);
    n.column = 10'(c);
    n.row = 12'(r);
    n.height_quarters = 9'(int'(self) - 64);
    n.normal_x = signed_unit(a, s);
    n.normal_y = 15'(unit_mag(8, s));
    n.normal_z = signed_unit(b, s);
    n.frame_end = last;
    return n;
  endfunction

  function automatic int field_check(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    normal_t got, want;
    int bad;
    bit last;
    if (!rst_ni) begin
      normal_q.delete();
      wr_col = 0; wr_row = 0; dr_col = 0; dr_row = 0; draining = 0;
      cfg_w = 1024; cfg_h = 1024;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      bad = 0;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_FRAME_WIDTH) cfg_w = cfg_data_i[10:0];
        else cfg_h = cfg_data_i;
      end
      if (pix_mon.valid && pix_mon.ready) begin
        if (draining) begin
          if (pix_mon.command) begin
            last = dr_col + 1 >= width_eff();
            normal_q = {normal_q, surface_normal(dr_col, dr_row, pix(dr_row, dr_col), last)};
            if (last) begin
              draining = 0; wr_col = 0; wr_row = 0; dr_col = 0; dr_row = 0;
            end else begin
              dr_col++;
            end
          end
        end else if (!pix_mon.command) begin
          line_mem[(wr_row % 3) * MaxW + wr_col] = pix_mon.sample;
          if (wr_row > 0)
            normal_q = {normal_q, surface_normal(wr_col, wr_row - 1, pix_mon.sample, 0)};
          if (wr_col + 1 >= width_eff()) begin
            wr_col = 0;
            if (wr_row + 1 >= height_eff()) begin
              draining = 1; dr_col = 0; dr_row = wr_row;
            end else begin
              wr_row++;
            end
          end else begin
            wr_col++;
          end
        end
      end
      if (nrm_mon.valid && nrm_mon.ready) begin
        got.column = nrm_mon.column;
        got.row = nrm_mon.row;
        got.height_quarters = nrm_mon.height_quarters;
        got.normal_x = nrm_mon.normal_x;
        got.normal_y = nrm_mon.normal_y;
        got.normal_z = nrm_mon.normal_z;
        got.frame_end = nrm_mon.frame_end;
        if (normal_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got %p", $time, got);
          bad = 1;
        end else begin
          want = normal_q.pop_front();
          bad += field_check("column", want.column, got.column);
          bad += field_check("row", want.row, got.row);
          bad += field_check("height_quarters", want.height_quarters, got.height_quarters);
          bad += field_check("normal_x", want.normal_x, got.normal_x);
          bad += field_check("normal_y", want.normal_y, got.normal_y);
          bad += field_check("normal_z", want.normal_z, got.normal_z);
          bad += field_check("frame_end", want.frame_end, got.frame_end);
          if (bad != 0) bad = 1;
        end
      end
      errors_o <= errors_o + bad;
      pending_o <= normal_q.size();
    end
  end
endmodule

// ----- tb/heightmap_normal_generator_test.sv -----
// Testbench top for the heightmap normal generator: clock, reset, config writes,
// pixel stimulus and output back-pressure; the checker does the scoring.
`timescale 1ns / 1ps
module heightmap_normal_generator_test;
  import hnm_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int Settle = 120;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;
  int errors, pending, cycles, items;
  int idle_pct, stall_pct;
  bit hold_req;

  hnm_in_if pix_ch();
  hnm_out_if nrm_ch();

  heightmap_normal_generator uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_i(pix_ch), .out_o(nrm_ch)
  );

  heightmap_normal_generator_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .pix_mon(pix_ch), .nrm_mon(nrm_ch), .errors_o(errors), .pending_o(pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("heightmap_normal_generator_test: done, errors");
      $finish;
    end
  end

  initial begin
    nrm_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        nrm_ch.ready <= 1'b0;
        repeat (600) @(posedge clk_i);
        hold_req = 0;
      end
      nrm_ch.ready <= ($urandom_range(99) < stall_pct) ? 1'b0 : 1'b1;
    end
  end

  task automatic send(logic cmd, logic [7:0] s);
    while ($urandom_range(99) < idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.command <= cmd;
    pix_ch.sample <= s;
    @(posedge clk_i);
    while (!pix_ch.ready) @(posedge clk_i);
    items++;
  endtask

  task automatic settle();
    pix_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, int val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CfgDataWidth'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mode 0 random bytes, 1 extremes, 2 ramp; noise in percent
  task automatic run_frame(int wr, int hr, int mode, int noise);
    int w, h;
    logic [7:0] s;
    settle();
    write_reg(CFG_FRAME_WIDTH, wr);
    write_reg(CFG_FRAME_HEIGHT, hr);
    w = wr < 1 ? 1 : (wr > 1024 ? 1024 : wr);
    h = hr < 1 ? 1 : (hr > 4096 ? 4096 : hr);
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < noise) send(1'b1, 8'($urandom));
      case (mode)
        1: s = $urandom_range(1) ? 8'hFF : 8'h00;
        2: s = 8'(i * 7);
        default: s = 8'($urandom);
      endcase
      send(1'b0, s);
    end
    for (int i = 0; i < w; i++) begin
      if ($urandom_range(99) < noise) send(1'b0, 8'($urandom));
      send(1'b1, 8'($urandom));
    end
  endtask

  initial begin
    int k;
    pix_ch.valid = 1'b0;
    pix_ch.command = 1'b0;
    pix_ch.sample = 8'h00;
    cycles = 0;
    items = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_frame(1, 1, 1, 0);
    run_frame(0, 0, 0, 50);
    run_frame(4, 1, 1, 30);
    run_frame(3, 3, 1, 20);
    run_frame(2, 4, 2, 0);

    k = 0;
    while (items < 1150) begin
      case (k % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 84; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 84; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      if (k == 4) hold_req = 1;
      if ($urandom_range(9) == 0) run_frame($urandom_range(40, 1), $urandom_range(4, 1), 0, 10);
      else run_frame($urandom_range(12, 1), $urandom_range(8, 1), $urandom_range(2), 8);
      k++;
    end

    settle();
    if (errors == 0) begin
      $display("heightmap_normal_generator_test: done, clean");
    end else begin
      $display("heightmap_normal_generator_test: done, errors");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/core/hnm_pkg.sv
rtl/core/hnm_if.sv
rtl/core/hnm_ram.sv
rtl/core/hnm_norm.sv
rtl/core/heightmap_normal_generator.sv
tb/heightmap_normal_generator_checker.sv
tb/heightmap_normal_generator_test.sv
